// ----- rtl/core/sces_pkg.sv -----
package sces_pkg;

  // Character codes that steer the scan
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // Scan modes; codes 5 to 7 never arise and act as normal copy
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESCAPE = 3'd1,
    MODE_HASH   = 3'd2,
    MODE_LINE   = 3'd3,
    MODE_BLOCK  = 3'd4
  } scan_mode_t;

endpackage

// ----- rtl/core/sces_if.sv -----
// Raw byte channel
interface sces_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

// Cleaned byte channel
interface sces_out_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] out_byte;
  logic       end_of_text;

  modport source (output valid, output has_byte, output out_byte, output end_of_text,
                  input ready);
  modport sink   (input valid, input has_byte, input out_byte, input end_of_text,
                  output ready);
endinterface

// ----- rtl/core/sces_in_reg.sv -----
module sces_in_reg (
  input logic       clk,
  input logic       rst,
  sces_in_if.sink   up,
  sces_in_if.source dn
);

  logic       vld;
  logic [7:0] text_byte;
  logic       last_byte;

  // Take a new beat when empty or when the held beat moves on
  assign up.ready = !vld || dn.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up.ready) begin
      vld <= up.valid;
    end
  end

  // Hold the payload while stalled
  always_ff @(posedge clk) begin
    if (up.valid && up.ready) begin
      text_byte <= up.text_byte;
      last_byte <= up.last_byte;
    end
  end

  assign dn.valid     = vld;
  assign dn.text_byte = text_byte;
  assign dn.last_byte = last_byte;

endmodule

// ----- rtl/core/sces_scan.sv -----
module sces_scan (
  input logic        clk,
  input logic        rst,
  sces_in_if.sink    up,
  sces_out_if.source dn
);

  sces_pkg::scan_mode_t scan_mode, scan_mode_next;
  logic                 quote_open, quote_open_next;
  logic                 prev_was_hash, prev_was_hash_next;

  logic       out_vld;
  logic       has_byte, has_byte_next;
  logic [7:0] out_byte, out_byte_next;
  logic       end_of_text;
  logic       adv;
  logic [7:0] b;
  logic       last;

  assign b    = up.text_byte;
  assign last = up.last_byte;

  // Result register is free when empty or being drained
  assign up.ready = !out_vld || dn.ready;
  assign adv      = up.valid && up.ready;

  // Decode one byte against the current mode
  always_comb begin
    scan_mode_next     = sces_pkg::MODE_NORMAL;
    quote_open_next    = quote_open;
    prev_was_hash_next = prev_was_hash;
    has_byte_next      = 1'b0;
    out_byte_next      = 8'h00;
    unique case (scan_mode)
      sces_pkg::MODE_ESCAPE: begin
        if (b == sces_pkg::CH_N) begin
          has_byte_next = 1'b1;
          out_byte_next = sces_pkg::CH_LF;
        end else if (b == sces_pkg::CH_T) begin
          has_byte_next = 1'b1;
          out_byte_next = sces_pkg::CH_TAB;
        end
      end
      sces_pkg::MODE_HASH: begin
        if (b == sces_pkg::CH_HASH) begin
          scan_mode_next     = sces_pkg::MODE_BLOCK;
          prev_was_hash_next = 1'b1;
        end else if (b != sces_pkg::CH_LF) begin
          scan_mode_next = sces_pkg::MODE_LINE;
        end
      end
      sces_pkg::MODE_LINE: begin
        if (b != sces_pkg::CH_LF) begin
          scan_mode_next = sces_pkg::MODE_LINE;
        end
      end
      sces_pkg::MODE_BLOCK: begin
        if (b == sces_pkg::CH_HASH && prev_was_hash) begin
          prev_was_hash_next = 1'b0;
        end else begin
          scan_mode_next     = sces_pkg::MODE_BLOCK;
          prev_was_hash_next = (b == sces_pkg::CH_HASH);
        end
      end
      default: begin
        if (b == sces_pkg::CH_QUOTE) begin
          quote_open_next = !quote_open;
        end
        if (b == sces_pkg::CH_BSLASH && !last) begin
          scan_mode_next = sces_pkg::MODE_ESCAPE;
        end else if (b == sces_pkg::CH_HASH && !quote_open_next) begin
          if (!last) begin
            scan_mode_next = sces_pkg::MODE_HASH;
          end
        end else begin
          has_byte_next = 1'b1;
          out_byte_next = b;
        end
      end
    endcase
    // Drop all scan state at the end of the text
    if (last) begin
      scan_mode_next     = sces_pkg::MODE_NORMAL;
      quote_open_next    = 1'b0;
      prev_was_hash_next = 1'b0;
    end
  end

  // Advance scan state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= sces_pkg::MODE_NORMAL;
      quote_open    <= 1'b0;
      prev_was_hash <= 1'b0;
    end else if (adv) begin
      scan_mode     <= scan_mode_next;
      quote_open    <= quote_open_next;
      prev_was_hash <= prev_was_hash_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (up.ready) begin
      out_vld <= up.valid;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (adv) begin
      has_byte    <= has_byte_next;
      out_byte    <= out_byte_next;
      end_of_text <= last;
    end
  end

  assign dn.valid       = out_vld;
  assign dn.has_byte    = has_byte;
  assign dn.out_byte    = out_byte;
  assign dn.end_of_text = end_of_text;

endmodule

// ----- rtl/core/script_comment_escape_stripper.sv -----
// An accepted input beat passes the input register, then the result register.
// Throughput: one byte per cycle while the output is not stalled; one result beat for every input beat.
// The scan state lives in registers (mode, quote, hash) updated as a byte enters the
// result register, so back-to-back bytes need no bubble.
// Reset (rst, synchronous): both pipeline stages empty, scan in normal copy
// mode outside quotes.
module script_comment_escape_stripper (
  input logic        clk,
  input logic        rst,
  sces_in_if.sink    text_in,
  sces_out_if.source text_out
);

  sces_in_if held ();

  sces_in_reg u_in_reg (
    .clk (clk),
    .rst (rst),
    .up  (text_in),
    .dn  (held.source)
  );

  sces_scan u_scan (
    .clk (clk),
    .rst (rst),
    .up  (held.sink),
    .dn  (text_out)
  );

  // An empty result carries a zero byte
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    text_out.valid && !text_out.has_byte |-> text_out.out_byte == 8'h00)
    else $error("empty result carries a nonzero byte");

  // A backslash only passes through as the final byte
  a_bslash_last: assert property (@(posedge clk) disable iff (rst)
    text_out.valid && text_out.has_byte && text_out.out_byte == sces_pkg::CH_BSLASH
    |-> text_out.end_of_text)
    else $error("backslash emitted before end of text");

  // Input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !text_in.ready |-> text_out.valid && !text_out.ready)
    else $error("input stalled with result side free");

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !text_out.valid)
    else $error("result valid after reset");

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_BYTES = 2000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } raw_beat_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       end_of_text;
  } clean_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sces_in_if  raw_ch ();
  sces_out_if clean_ch ();

  script_comment_escape_stripper uut (
    .clk      (clk),
    .rst      (rst),
    .text_in  (raw_ch),
    .text_out (clean_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  raw_beat_t   raw_queue[$];
  clean_beat_t clean_expected[$];
  int          error_count = 0;
  int          send_gap = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  bit          no_idle = 1'b0;

  // Stripper state as seen by the predictor
  sces_pkg::scan_mode_t scan_mode = sces_pkg::MODE_NORMAL;
  logic                 in_quote = 1'b0;
  logic                 hash_seen = 1'b0;

  // Work out the cleaned beat for one raw byte and advance the scan state
  function automatic clean_beat_t strip_byte(input logic [7:0] b, input logic last);
    clean_beat_t res;
    res = '0;
    res.end_of_text = last;
    case (scan_mode)
      sces_pkg::MODE_ESCAPE: begin
        if (b == sces_pkg::CH_N) begin
          res.has_byte = 1'b1;
          res.out_byte = sces_pkg::CH_LF;
        end else if (b == sces_pkg::CH_T) begin
          res.has_byte = 1'b1;
          res.out_byte = sces_pkg::CH_TAB;
        end
        scan_mode = sces_pkg::MODE_NORMAL;
      end
      sces_pkg::MODE_HASH: begin
        if (b == sces_pkg::CH_HASH) begin
          scan_mode = sces_pkg::MODE_BLOCK;
          hash_seen = 1'b1;
        end else if (b == sces_pkg::CH_LF) begin
          scan_mode = sces_pkg::MODE_NORMAL;
        end else begin
          scan_mode = sces_pkg::MODE_LINE;
        end
      end
      sces_pkg::MODE_LINE: begin
        if (b == sces_pkg::CH_LF) scan_mode = sces_pkg::MODE_NORMAL;
      end
      sces_pkg::MODE_BLOCK: begin
        if (b == sces_pkg::CH_HASH && hash_seen) begin
          scan_mode = sces_pkg::MODE_NORMAL;
          hash_seen = 1'b0;
        end else begin
          hash_seen = (b == sces_pkg::CH_HASH);
        end
      end
      default: begin
        scan_mode = sces_pkg::MODE_NORMAL;
        if (b == sces_pkg::CH_QUOTE) in_quote = ~in_quote;
        if (b == sces_pkg::CH_BSLASH && !last) begin
          scan_mode = sces_pkg::MODE_ESCAPE;
        end else if (b == sces_pkg::CH_HASH && !in_quote) begin
          if (!last) scan_mode = sces_pkg::MODE_HASH;
        end else begin
          res.has_byte = 1'b1;
          res.out_byte = b;
        end
      end
    endcase
    // Close whatever is open at the end of the text
    if (last) begin
      scan_mode = sces_pkg::MODE_NORMAL;
      in_quote = 1'b0;
      hash_seen = 1'b0;
    end
    return res;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a stretch without any
  function automatic int idle_length();
    int r;
    if ($urandom_range(0, 199) == 0) no_idle = ~no_idle;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Favor the bytes that steer the scan
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0:       return sces_pkg::CH_QUOTE;
      1:       return sces_pkg::CH_BSLASH;
      2:       return sces_pkg::CH_N;
      3:       return sces_pkg::CH_T;
      4, 5:    return sces_pkg::CH_HASH;
      6:       return sces_pkg::CH_LF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic queue_text(input logic [7:0] txt[$]);
    raw_beat_t beat;
    for (int i = 0; i < txt.size(); i++) begin
      beat.text_byte = txt[i];
      beat.last_byte = (i == txt.size() - 1);
      raw_queue.push_back(beat);
    end
  endtask

  task automatic queue_string(input string s);
    logic [7:0] txt[$];
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    queue_text(txt);
  endtask

  // Build one text from escapes, quoted runs, comments and loose bytes
  task automatic queue_random_text(output int n);
    logic [7:0] txt[$];
    int pieces;
    int body;
    pieces = $urandom_range(1, 8);
    for (int p = 0; p < pieces; p++) begin
      body = $urandom_range(0, 5);
      case ($urandom_range(0, 5))
        0: txt.push_back(pick_byte());
        1: begin
          txt.push_back(sces_pkg::CH_BSLASH);
          txt.push_back(pick_byte());
        end
        2: begin
          txt.push_back(sces_pkg::CH_QUOTE);
          for (int i = 0; i < body; i++) txt.push_back(pick_byte());
          txt.push_back(sces_pkg::CH_QUOTE);
        end
        3: begin
          txt.push_back(sces_pkg::CH_HASH);
          for (int i = 0; i < body; i++) txt.push_back(pick_byte());
          if ($urandom_range(0, 3) != 0) txt.push_back(sces_pkg::CH_LF);
        end
        4: begin
          txt.push_back(sces_pkg::CH_HASH);
          txt.push_back(sces_pkg::CH_HASH);
          for (int i = 0; i < body; i++) txt.push_back(pick_byte());
          if ($urandom_range(0, 3) != 0) begin
            txt.push_back(sces_pkg::CH_HASH);
            txt.push_back(sces_pkg::CH_HASH);
          end
        end
        default: begin
          for (int i = 0; i <= body; i++) txt.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
    n = txt.size();
    queue_text(txt);
  endtask

  // Drive raw beats; predict each one as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      raw_ch.valid <= 1'b0;
      raw_ch.text_byte <= 8'h00;
      raw_ch.last_byte <= 1'b0;
      send_gap <= 0;
    end else begin
      if (raw_ch.valid && raw_ch.ready)
        clean_expected.push_back(strip_byte(raw_ch.text_byte, raw_ch.last_byte));
      if (!raw_ch.valid || raw_ch.ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          raw_ch.valid <= 1'b0;
        end else if (raw_queue.size() != 0) begin
          raw_ch.text_byte <= raw_queue[0].text_byte;
          raw_ch.last_byte <= raw_queue[0].last_byte;
          raw_ch.valid <= 1'b1;
          raw_queue.pop_front();
          send_gap <= idle_length();
        end else begin
          raw_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Accept cleaned beats with random stalls and check them in order
  always @(posedge clk) begin
    if (rst) begin
      clean_ch.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (clean_ch.valid && clean_ch.ready) begin
        if (clean_expected.size() == 0) begin
          $error("cleaned beat with nothing expected: has_byte %0d out_byte %02h end_of_text %0d",
                 clean_ch.has_byte, clean_ch.out_byte, clean_ch.end_of_text);
          error_count++;
        end else begin
          if (clean_ch.has_byte !== clean_expected[0].has_byte) begin
            $error("has_byte: expected %0d, actual %0d",
                   clean_expected[0].has_byte, clean_ch.has_byte);
            error_count++;
          end
          if (clean_ch.out_byte !== clean_expected[0].out_byte) begin
            $error("out_byte: expected %02h, actual %02h",
                   clean_expected[0].out_byte, clean_ch.out_byte);
            error_count++;
          end
          if (clean_ch.end_of_text !== clean_expected[0].end_of_text) begin
            $error("end_of_text: expected %0d, actual %0d",
                   clean_expected[0].end_of_text, clean_ch.end_of_text);
            error_count++;
          end
          clean_expected.pop_front();
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        clean_ch.ready <= 1'b0;
      end else begin
        clean_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left <= idle_length();
      end
    end
  end

  // Give up when neither side moves a beat for too long
  always @(posedge clk) begin
    if (rst || (raw_ch.valid && raw_ch.ready) || (clean_ch.valid && clean_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [7:0] one[$];
    int queued;
    int n;
    raw_ch.valid = 1'b0;
    raw_ch.text_byte = 8'h00;
    raw_ch.last_byte = 1'b0;
    clean_ch.ready = 1'b0;

    // Quotes, hash in quotes, escaped quote
    queue_string("'#\\'x");
    // Tab and line feed escapes, and one that drops both bytes
    queue_string("\\n\\t\\q");
    // Line comment holding a quote, closed by a line feed
    queue_string("#c'\nA");
    // Block comment closed by the hash right after its opening pair
    queue_string("###x");
    // Backslash at the end, lone hash at the end, unclosed block comment
    queue_string("\\");
    queue_string("#");
    queue_string("##'");
    // Extreme byte values
    one = '{8'h00};
    queue_text(one);
    one = '{8'hFF};
    queue_text(one);

    queued = 0;
    while (queued < RANDOM_BYTES) begin
      queue_random_text(n);
      queued += n;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Hold until every byte is sent and every cleaned beat checked
    @(negedge clk);
    while (raw_queue.size() != 0 || raw_ch.valid || clean_expected.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ----- script_comment_escape_stripper.f -----
rtl/core/sces_pkg.sv
rtl/core/sces_if.sv
rtl/core/sces_in_reg.sv
rtl/core/sces_scan.sv
rtl/core/script_comment_escape_stripper.sv
tb/sv/testbench.sv
